// ===== rtl/bse_pkg.sv =====
`default_nettype none

package bse_pkg;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    is_last;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_value;
        logic                    end_of_set;
        logic                    overflowed;
    } out_word_t;

    typedef enum logic [1:0] {
        WSEL_KEY,
        WSEL_RDATA,
        WSEL_HOLD
    } wr_sel_t;

    typedef struct packed {
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    hold_ld;
        logic    out_load;
        logic    out_eos;
        logic    out_ovf;
    } cmd_t;

    typedef struct packed {
        logic gt;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/bse_ram.sv =====
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bse_datapath.sv =====
`default_nettype none

module bse_datapath #(
    parameter int MAX_KEYS = 64,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bse_pkg::cmd_t      cmd,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [AW-1:0]      rd_addr,
    input  wire logic [bse_pkg::KEY_W-1:0] in_key,
    output bse_pkg::status_t        status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bse_pkg::out_word_t      out_data
);

    logic [bse_pkg::KEY_W-1:0] rd_data;
    logic [bse_pkg::KEY_W-1:0] wr_data;
    logic [bse_pkg::KEY_W-1:0] hold_reg;
    logic [bse_pkg::KEY_W-1:0] hold_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    bse_pkg::out_word_t        out_data_reg;
    bse_pkg::out_word_t        out_data_next;

    bse_ram #(
        .WIDTH (bse_pkg::KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (cmd.wr_sel)
            bse_pkg::WSEL_KEY:   wr_data = in_key;
            bse_pkg::WSEL_RDATA: wr_data = rd_data;
            bse_pkg::WSEL_HOLD:  wr_data = hold_reg;
            default:             wr_data = hold_reg;
        endcase
    end

    assign hold_next = cmd.hold_ld ? rd_data : hold_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (cmd.out_load)
        begin
            out_valid_next             = 1'b1;
            out_data_next.sorted_value = $signed(rd_data);
            out_data_next.end_of_set   = cmd.out_eos;
            out_data_next.overflowed   = cmd.out_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.gt       = $signed(hold_reg) > $signed(rd_data);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("output register loaded while still holding a word");

    a_hold_and_write_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.hold_ld && cmd.wr_en) |-> (cmd.wr_sel == bse_pkg::WSEL_HOLD))
        else $error("hold reload with a write of anything but the old hold");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending output word changed before it was taken");

endmodule

`default_nettype wire

// ===== rtl/bse_controller.sv =====
`default_nettype none

module bse_controller #(
    parameter int MAX_KEYS = 64,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int CW = $clog2(MAX_KEYS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_is_last,
    input  wire bse_pkg::status_t  status,
    output bse_pkg::cmd_t          cmd,
    output logic [AW-1:0]          wr_addr,
    output logic [AW-1:0]          rd_addr
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_PASS_FIRST,
        ST_PASS_CMP,
        ST_PASS_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_KEYS);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          in_fire;
    logic          stored;
    logic [CW-1:0] count_inc;
    logic [AW-1:0] pos_inc;
    logic [CW-1:0] idx_inc;

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign stored    = count_reg < MAX_COUNT;
    assign count_inc = count_reg + CW'(stored);
    assign pos_inc   = pos_reg + AW'(1);
    assign idx_inc   = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.wr_sel = bse_pkg::WSEL_KEY;
        wr_addr    = count_reg[AW-1:0];
        rd_addr    = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    cmd.wr_en  = stored;
                    count_next = count_inc;
                    ovf_next   = ovf_reg || !stored;
                    if (in_is_last)
                    begin
                        idx_next  = '0;
                        last_next = AW'(count_inc - CW'(1));
                        if (count_inc >= CW'(2))
                        begin
                            state_next = ST_SORT_START;
                        end
                        else
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_SORT_START:
            begin
                state_next = ST_PASS_FIRST;
            end
            ST_PASS_FIRST:
            begin
                cmd.hold_ld = 1'b1;
                rd_addr     = AW'(1);
                pos_next    = '0;
                state_next  = ST_PASS_CMP;
            end
            ST_PASS_CMP:
            begin
                cmd.wr_en   = 1'b1;
                wr_addr     = pos_reg;
                cmd.wr_sel  = status.gt ? bse_pkg::WSEL_RDATA : bse_pkg::WSEL_HOLD;
                cmd.hold_ld = !status.gt;
                rd_addr     = pos_reg + AW'(2);
                pos_next    = pos_inc;
                if (pos_inc == last_reg)
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END:
            begin
                cmd.wr_en  = 1'b1;
                wr_addr    = last_reg;
                cmd.wr_sel = bse_pkg::WSEL_HOLD;
                last_next  = last_reg - AW'(1);
                if (last_reg == AW'(1))
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_PASS_FIRST;
                end
            end
            ST_EMIT_RD:
            begin
                rd_addr = idx_reg;
                if (status.out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_eos  = (idx_inc == count_reg);
                cmd.out_ovf  = ovf_reg;
                if (idx_inc == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next   = idx_inc[AW-1:0];
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= '0;
            pos_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("key count beyond buffer capacity");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS_CMP) |-> (pos_reg < last_reg && CW'(last_reg) < count_reg))
        else $error("compare position outside the active part of the pass");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output word loaded while the output register is busy");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD) |-> (count_reg != '0 && CW'(idx_reg) < count_reg))
        else $error("emit index outside the stored set");

endmodule

`default_nettype wire

// ===== rtl/bubble_sort_engine_unit.sv =====
// keys load one per cycle while in_ready is high; a last word sorts the n stored keys
// each pass loads the hold register, then does one ram compare and write per cycle
// results leave one at a time via a registered ram read, each when the output is free
// no key is taken from the end of a set until its last result is in the output register
// rst_n is asynchronous, active low: empties the set, clears overflow and output valid
`default_nettype none

module bubble_sort_engine_unit #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bse_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bse_pkg::out_word_t      out_data
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    bse_pkg::cmd_t    cmd;
    bse_pkg::status_t status;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    bse_controller #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_is_last (in_data.is_last),
        .status     (status),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    bse_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .in_key    (in_data.key_value),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
